### hw/rtl/mbd_pkg.sv
// Shared types and constants for the multi-button debouncer.
// Holds the operation codes, register map, lane structs and default sizes.
// No dependencies.
`default_nettype none

package mbd_pkg;

   // Default sizes
   localparam int unsigned BUTTONS_DEF   = 7;
   localparam int unsigned TIME_BITS_DEF = 32;

   // Fixed field widths
   localparam int unsigned OP_W    = 2;
   localparam int unsigned PINS_W  = 7;
   localparam int unsigned NOW_W   = 32;
   localparam int unsigned INDEX_W = 3;
   localparam int unsigned DEB_W   = 16;
   localparam int unsigned CSR_AW  = 3;
   localparam int unsigned CSR_DW  = 32;

   // Register map and reset value
   localparam logic [CSR_AW-1:0] ADDR_DEBOUNCE  = 3'd0;
   localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 16'd20;

   // Request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_SAMPLE   = 2'd0,
      OP_PRESSED  = 2'd1,
      OP_RELEASED = 2'd2
   } op_type;

   // Per-lane commands from the front end
   typedef struct packed {
      logic sample;
      logic clr_pressed;
      logic clr_released;
   } lane_ctrl_type;

   // Per-lane latched events
   typedef struct packed {
      logic pressed;
      logic released;
   } lane_flags_type;

endpackage

`default_nettype wire

### hw/rtl/mbd_lane.sv
// One debounce lane: raw level, change timestamp, stable level and event flags.
// Depends on mbd_pkg.
`default_nettype none

module mbd_lane #(
   parameter int unsigned TIME_BITS = mbd_pkg::TIME_BITS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  mbd_pkg::lane_ctrl_type       ctrl,
   input  wire                          pin_level,
   input  wire [TIME_BITS-1:0]          now,
   input  wire [mbd_pkg::DEB_W-1:0]     debounce,
   output mbd_pkg::lane_flags_type      flags
);
   import mbd_pkg::*;

   logic                 raw_ff, raw_in;
   logic                 stable_ff, stable_in;
   logic                 pressed_ff, pressed_in;
   logic                 released_ff, released_in;
   logic [TIME_BITS-1:0] change_time_ff, change_time_in;

   logic                 raw_changed;
   logic [TIME_BITS-1:0] elapsed;
   logic                 settled;
   logic                 commit;

   // Detect a raw change and measure time since the last one
   always_comb begin
      raw_changed = ctrl.sample && (pin_level != raw_ff);
      elapsed     = raw_changed ? '0 : (now - change_time_ff);
      settled     = 32'(elapsed) >= {16'd0, debounce};
      commit      = ctrl.sample && settled;
   end

   // Advance raw, stable and flag state
   always_comb begin
      raw_in         = ctrl.sample ? pin_level : raw_ff;
      change_time_in = raw_changed ? now : change_time_ff;
      stable_in      = commit ? raw_in : stable_ff;
      pressed_in     = (commit && stable_ff && !raw_in) ||
                       (pressed_ff && !ctrl.clr_pressed);
      released_in    = (commit && !stable_ff && raw_in) ||
                       (released_ff && !ctrl.clr_released);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff         <= 1'b1;
         stable_ff      <= 1'b1;
         pressed_ff     <= 1'b0;
         released_ff    <= 1'b0;
         change_time_ff <= '0;
      end else begin
         raw_ff         <= raw_in;
         stable_ff      <= stable_in;
         pressed_ff     <= pressed_in;
         released_ff    <= released_in;
         change_time_ff <= change_time_in;
      end
   end

   assign flags.pressed  = pressed_ff;
   assign flags.released = released_ff;

   // A press event appears only on a sample
   a_press_from_sample: assert property (@(posedge clock) disable iff (reset)
      $rose(pressed_ff) |-> $past(ctrl.sample))
      else $error("pressed flag set without a sample");

   // A press event leaves the stable level low
   a_press_stable_low: assert property (@(posedge clock) disable iff (reset)
      $rose(pressed_ff) |-> !stable_ff)
      else $error("pressed flag set with stable level high");

   // A clear without a sample drops the flag
   a_clear_drops: assert property (@(posedge clock) disable iff (reset)
      (ctrl.clr_pressed && !ctrl.sample) |=> !pressed_ff)
      else $error("pressed flag survived a clear");

endmodule

`default_nettype wire

### hw/rtl/mbd_merge.sv
// Query merge: picks the addressed lane's flag and builds per-lane clears.
// Depends on mbd_pkg.
`default_nettype none

module mbd_merge #(
   parameter int unsigned BUTTONS = mbd_pkg::BUTTONS_DEF
) (
   input  wire                           query,
   input  wire [mbd_pkg::OP_W-1:0]       op,
   input  wire [mbd_pkg::INDEX_W-1:0]    index,
   input  mbd_pkg::lane_flags_type       flags [BUTTONS],
   output logic                          clr_pressed [BUTTONS],
   output logic                          clr_released [BUTTONS],
   output logic                          seen
);
   import mbd_pkg::*;

   logic [BUTTONS-1:0] hit;
   logic [BUTTONS-1:0] pick;

   // Decode the index against each lane and gather the selected flag
   always_comb begin
      for (int i = 0; i < BUTTONS; i++) begin
         hit[i] = ({29'd0, index} == 32'(i));
         case (op)
            OP_PRESSED:  pick[i] = flags[i].pressed;
            OP_RELEASED: pick[i] = flags[i].released;
            default:     pick[i] = 1'b0;
         endcase
         clr_pressed[i]  = query && hit[i] && (op == OP_PRESSED);
         clr_released[i] = query && hit[i] && (op == OP_RELEASED);
      end
      seen = |(hit & pick);
   end

endmodule

`default_nettype wire

### hw/rtl/multi_button_debouncer_unit.sv
// Top level of the multi-button debouncer: CSR port, lanes, merge, response register.
// Depends on mbd_pkg, mbd_lane and mbd_merge.
// Throughput: one request per cycle; a held response stalls requests until taken.
// A query result is loaded into the response register at its accept edge.
// A sample gives no response; it only updates lane state at its accept edge.
// Reset (synchronous): lanes to raw/stable 1, flags and timestamps 0, debounce 20.
`default_nettype none

module multi_button_debouncer_unit #(
   parameter int unsigned BUTTONS   = mbd_pkg::BUTTONS_DEF,
   parameter int unsigned TIME_BITS = mbd_pkg::TIME_BITS_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   // request channel
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire [mbd_pkg::OP_W-1:0]       req_op,
   input  wire [mbd_pkg::PINS_W-1:0]     req_pin_levels,
   input  wire [mbd_pkg::NOW_W-1:0]      req_now_ms,
   input  wire [mbd_pkg::INDEX_W-1:0]    req_button_index,
   // response channel
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output logic                          rsp_event_seen,
   // configuration port
   input  wire                           csr_psel,
   input  wire                           csr_penable,
   input  wire                           csr_pwrite,
   input  wire [mbd_pkg::CSR_AW-1:0]     csr_paddr,
   input  wire [mbd_pkg::CSR_DW-1:0]     csr_pwdata,
   output logic [mbd_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import mbd_pkg::*;

   logic [DEB_W-1:0] debounce_ff, debounce_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_seen_ff, rsp_seen_in;

   logic             accept;
   logic             is_sample;
   logic             is_query;
   logic             seen;
   logic             clr_pressed  [BUTTONS];
   logic             clr_released [BUTTONS];
   lane_ctrl_type    ctrl  [BUTTONS];
   lane_flags_type   flags [BUTTONS];

   // Configuration register
   always_comb begin
      debounce_in = debounce_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == ADDR_DEBOUNCE[2])) begin
         debounce_in = csr_pwdata[DEB_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
      end else begin
         debounce_ff <= debounce_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == ADDR_DEBOUNCE[2]) ?
                       {{(CSR_DW-DEB_W){1'b0}}, debounce_ff} : '0;

   // Accept a request whenever the response slot is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_sample = accept && (req_op == OP_SAMPLE);
   assign is_query  = accept && ((req_op == OP_PRESSED) || (req_op == OP_RELEASED));

   // Query merge across lanes
   mbd_merge #(
      .BUTTONS (BUTTONS)
   ) u_merge (
      .query        (is_query),
      .op           (req_op),
      .index        (req_button_index),
      .flags        (flags),
      .clr_pressed  (clr_pressed),
      .clr_released (clr_released),
      .seen         (seen)
   );

   // Debounce lanes
   for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
      logic raw_bit;
      if (g < PINS_W) begin : g_pin
         assign raw_bit = req_pin_levels[g];
      end else begin : g_zero
         assign raw_bit = 1'b0;
      end

      assign ctrl[g].sample       = is_sample;
      assign ctrl[g].clr_pressed  = clr_pressed[g];
      assign ctrl[g].clr_released = clr_released[g];

      mbd_lane #(
         .TIME_BITS (TIME_BITS)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl[g]),
         .pin_level (raw_bit),
         .now       (req_now_ms[TIME_BITS-1:0]),
         .debounce  (debounce_ff),
         .flags     (flags[g])
      );
   end

   // Response register: load on query, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_seen_in  = rsp_seen_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (is_query) begin
         rsp_valid_in = 1'b1;
         rsp_seen_in  = seen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_seen_ff <= rsp_seen_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_seen = rsp_seen_ff;

   // A query always produces a response
   a_query_rsp: assert property (@(posedge clock) disable iff (reset)
      is_query |=> rsp_valid_ff)
      else $error("query accepted without a response");

   // A sample on a free slot gives no response
   a_sample_silent: assert property (@(posedge clock) disable iff (reset)
      (is_sample && (!rsp_valid_ff || rsp_ready)) |=> !rsp_valid_ff)
      else $error("sample produced a response");

   // An index past the last button reads zero
   a_oob_zero: assert property (@(posedge clock) disable iff (reset)
      (is_query && ({29'd0, req_button_index} >= 32'(BUTTONS))) |=> !rsp_seen_ff)
      else $error("out of range query returned an event");

endmodule

`default_nettype wire

### verif/mbd_checker.sv
// Scoreboard for the multi-button debouncer: watches the request, response and CSR ports,
// predicts every flag read and compares it with the response that comes back.
// Depends on mbd_pkg.
`timescale 1ns / 1ps

module mbd_checker #(
   parameter int unsigned BUTTONS = mbd_pkg::BUTTONS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   input  wire                          req_ready,
   input  wire [mbd_pkg::OP_W-1:0]      req_op,
   input  wire [mbd_pkg::PINS_W-1:0]    req_pin_levels,
   input  wire [mbd_pkg::NOW_W-1:0]     req_now_ms,
   input  wire [mbd_pkg::INDEX_W-1:0]   req_button_index,
   input  wire                          rsp_valid,
   input  wire                          rsp_ready,
   input  wire                          rsp_event_seen,
   input  wire                          csr_psel,
   input  wire                          csr_penable,
   input  wire                          csr_pwrite,
   input  wire                          csr_pready,
   input  wire [mbd_pkg::CSR_AW-1:0]    csr_paddr,
   input  wire [mbd_pkg::CSR_DW-1:0]    csr_pwdata,
   output int                           mismatch_count,
   output int                           pending_count
);
   import mbd_pkg::*;

   // One outstanding flag read and the value it must return
   typedef struct packed {
      op_type              op;
      logic [INDEX_W-1:0]  button;
      logic                seen;
   } flag_read_type;

   flag_read_type flag_reads_due[$];

   // Predicted per-button state and the debounce setting
   logic [BUTTONS-1:0] raw_lvl;
   logic [BUTTONS-1:0] stable_lvl;
   logic [BUTTONS-1:0] pressed_lat;
   logic [BUTTONS-1:0] released_lat;
   logic [NOW_W-1:0]   changed_at [BUTTONS];
   logic [DEB_W-1:0]   window_ms;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   // Run one pin sample through every debounce channel
   task automatic debounce_sample(input logic [PINS_W-1:0] pins, input logic [NOW_W-1:0] now);
      int i;
      logic pin;
      logic was_stable;
      logic [NOW_W-1:0] elapsed;
      for (i = 0; i < BUTTONS; i++) begin
         // pins beyond the field read as low
         pin = (i < PINS_W) ? pins[i] : 1'b0;
         if (pin != raw_lvl[i]) begin
            raw_lvl[i]    = pin;
            changed_at[i] = now;
         end
         elapsed = now - changed_at[i];
         if (elapsed >= window_ms) begin
            was_stable    = stable_lvl[i];
            stable_lvl[i] = raw_lvl[i];
            if (was_stable && !raw_lvl[i]) pressed_lat[i] = 1'b1;
            if (!was_stable && raw_lvl[i]) released_lat[i] = 1'b1;
         end
      end
   endtask

   // Read one latched flag and clear it; out-of-range buttons read as zero
   task automatic take_flag(input op_type op, input logic [INDEX_W-1:0] button,
                            output logic seen);
      seen = 1'b0;
      if (button < BUTTONS) begin
         if (op == OP_PRESSED) begin
            seen = pressed_lat[button];
            pressed_lat[button] = 1'b0;
         end else begin
            seen = released_lat[button];
            released_lat[button] = 1'b0;
         end
      end
   endtask

   always @(posedge clock) begin
      flag_read_type due;
      logic          seen;
      if (reset) begin
         raw_lvl      = '1;
         stable_lvl   = '1;
         pressed_lat  = '0;
         released_lat = '0;
         for (int i = 0; i < BUTTONS; i++) changed_at[i] = '0;
         window_ms    = DEBOUNCE_RESET;
         flag_reads_due.delete();
      end else begin
         // track register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == ADDR_DEBOUNCE)
            window_ms = csr_pwdata[DEB_W-1:0];

         // compare the response against the oldest flag read
         if (rsp_valid && rsp_ready) begin
            if (flag_reads_due.size() == 0) begin
               $display("%0t: response with no request waiting: expected none, got %0b",
                        $time, rsp_event_seen);
               mismatch_count++;
            end else begin
               due = flag_reads_due.pop_front();
               if (rsp_event_seen !== due.seen) begin
                  $display("%0t: %s read of button %0d: expected %0b, got %0b", $time,
                           due.op.name(), due.button, due.seen, rsp_event_seen);
                  mismatch_count++;
               end
            end
         end

         // advance the prediction on each accepted request
         if (req_valid && req_ready) begin
            case (req_op)
               OP_SAMPLE: begin
                  debounce_sample(req_pin_levels, req_now_ms);
               end
               OP_PRESSED, OP_RELEASED: begin
                  take_flag(op_type'(req_op), req_button_index, seen);
                  due.op     = op_type'(req_op);
                  due.button = req_button_index;
                  due.seen   = seen;
                  flag_reads_due.push_back(due);
               end
               default: begin
                  // unused op: no state change, no response
               end
            endcase
         end
      end
      pending_count = flag_reads_due.size();
   end

endmodule

### verif/multi_button_debouncer_unit_test.sv
// Testbench top for the multi-button debouncer: clock, reset, request and CSR stimulus,
// response-side back-pressure, watchdog and final verdict.
// Depends on mbd_pkg, multi_button_debouncer_unit and mbd_checker.
`timescale 1ns / 1ps

module multi_button_debouncer_unit_test;
   import mbd_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int unsigned     IDLE_LIMIT = 4000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [OP_W-1:0]     req_op;
   logic [PINS_W-1:0]   req_pin_levels;
   logic [NOW_W-1:0]    req_now_ms;
   logic [INDEX_W-1:0]  req_button_index;
   logic                rsp_valid;
   logic                rsp_ready;
   logic                rsp_event_seen;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CSR_AW-1:0]   csr_paddr;
   logic [CSR_DW-1:0]   csr_pwdata;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   int                  mismatch_count;
   int                  pending_count;

   // stimulus shaping shared between the request and response sides
   bit                  req_no_idle;
   bit                  rsp_no_idle;
   int unsigned         rsp_hold_cycles;
   int unsigned         items_sent;
   int unsigned         debounce_cfg;
   logic [NOW_W-1:0]    time_ms;
   logic [PINS_W-1:0]   pin_state;
   int unsigned         idle_cycles;

   multi_button_debouncer_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_pin_levels   (req_pin_levels),
      .req_now_ms       (req_now_ms),
      .req_button_index (req_button_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_seen   (rsp_event_seen),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   mbd_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_pin_levels   (req_pin_levels),
      .req_now_ms       (req_now_ms),
      .req_button_index (req_button_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_seen   (rsp_event_seen),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_pready       (csr_pready),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count)
   );

   // 2 ns clock
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Drop the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Response side: random hold-offs, free-running stretches and one long stall
   initial begin
      int unsigned wait_cycles;
      rsp_ready = 1'b0;
      forever begin
         if (rsp_hold_cycles > 0) begin
            wait_cycles     = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else if (rsp_no_idle) begin
            wait_cycles = 0;
         end else begin
            wait_cycles = $urandom_range(0, 17);
         end
         if (wait_cycles > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (wait_cycles - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Offer one request after a random gap and hold it until accepted
   task automatic send_request(input logic [OP_W-1:0] op, input logic [PINS_W-1:0] pins,
                               input logic [NOW_W-1:0] now, input logic [INDEX_W-1:0] idx);
      int unsigned gap;
      gap = req_no_idle ? 0 : $urandom_range(0, 17);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= op;
      req_pin_levels   <= pins;
      req_now_ms       <= now;
      req_button_index <= idx;
      do @(posedge clock); while (!req_ready);
      if (op != OP_UNUSED) items_sent++;
   endtask

   // Stop offering and wait until every flag read has come back
   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Two-phase register write; upper data bits carry noise
   task automatic write_debounce(input logic [DEB_W-1:0] value);
      logic [CSR_DW-1:0] noise;
      noise       = $urandom;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_DEBOUNCE;
      csr_pwdata  <= {noise[CSR_DW-1:DEB_W], value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      debounce_cfg = value;
   endtask

   // Time step that stays well inside the debounce window when the window is above 3
   function automatic logic [NOW_W-1:0] bounce_step();
      return (debounce_cfg > 3) ? $urandom_range(0, debounce_cfg / 3) : $urandom_range(0, 1);
   endfunction

   // Bounce one button, settle it past the window, then mostly read the flag it latched
   task automatic press_sequence();
      int unsigned btn;
      int unsigned bounces;
      int unsigned k;
      logic [PINS_W-1:0] target;
      logic [PINS_W-1:0] extra;
      btn = $urandom_range(0, PINS_W - 1);
      target = pin_state;
      target[btn] = ~target[btn];
      extra = PINS_W'($urandom);
      if ($urandom_range(0, 3) == 0) target = target ^ extra;
      bounces = $urandom_range(0, 3);
      for (k = 0; k < bounces; k++) begin
         time_ms = time_ms + bounce_step();
         send_request(OP_SAMPLE, (k % 2 == 0) ? target : pin_state, time_ms,
                      INDEX_W'($urandom_range(0, 7)));
      end
      time_ms = time_ms + bounce_step();
      send_request(OP_SAMPLE, target, time_ms, INDEX_W'($urandom_range(0, 7)));
      // one short of the window now and then
      if (debounce_cfg > 0 && $urandom_range(0, 1) == 1)
         send_request(OP_SAMPLE, target, time_ms + debounce_cfg - 1,
                      INDEX_W'($urandom_range(0, 7)));
      time_ms = time_ms + debounce_cfg + $urandom_range(0, 2);
      send_request(OP_SAMPLE, target, time_ms, INDEX_W'($urandom_range(0, 7)));
      pin_state = target;
      if ($urandom_range(0, 3) != 0)
         send_request(target[btn] ? OP_RELEASED : OP_PRESSED, PINS_W'($urandom), $urandom,
                      INDEX_W'(btn));
   endtask

   // Mix of press sequences, random reads and noise until the phase quota is sent
   task automatic run_phase(input int unsigned count);
      int unsigned stop_at;
      int unsigned pick;
      logic [OP_W-1:0]   op_code;
      logic [PINS_W-1:0] pins;
      logic [NOW_W-1:0]  now_pick;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 19) == 0) req_no_idle = !req_no_idle;
         if ($urandom_range(0, 19) == 0) rsp_no_idle = !rsp_no_idle;
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            press_sequence();
         end else if (pick < 8) begin
            send_request($urandom_range(0, 1) ? OP_PRESSED : OP_RELEASED, PINS_W'($urandom),
                         $urandom, INDEX_W'($urandom_range(0, 7)));
         end else begin
            op_code  = OP_W'($urandom_range(0, 3));
            pins     = PINS_W'($urandom);
            now_pick = ($urandom_range(0, 3) == 0) ? $urandom : time_ms + $urandom_range(0, 3);
            send_request(op_code, pins, now_pick, INDEX_W'($urandom_range(0, 7)));
            if (op_code == OP_SAMPLE) begin
               pin_state = pins;
               time_ms   = now_pick;
            end
         end
      end
   endtask

   // Main stimulus and verdict
   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_op           = OP_SAMPLE;
      req_pin_levels   = '0;
      req_now_ms       = '0;
      req_button_index = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      req_no_idle      = 1'b0;
      rsp_no_idle      = 1'b0;
      rsp_hold_cycles  = 0;
      items_sent       = 0;
      debounce_cfg     = DEBOUNCE_RESET;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty flags, out-of-range reads, window edge, wrap of the time base
      send_request(OP_PRESSED, PINS_W'($urandom), $urandom, 3'd0);
      send_request(OP_RELEASED, PINS_W'($urandom), $urandom, 3'd6);
      send_request(OP_PRESSED, PINS_W'($urandom), $urandom, 3'd7);
      send_request(OP_RELEASED, PINS_W'($urandom), $urandom, 3'd7);
      send_request(OP_SAMPLE, 7'h00, 32'd100, 3'd7);
      send_request(OP_SAMPLE, 7'h00, 32'd119, 3'd0);
      send_request(OP_SAMPLE, 7'h00, 32'd120, 3'd5);
      send_request(OP_PRESSED, PINS_W'($urandom), $urandom, 3'd0);
      send_request(OP_PRESSED, PINS_W'($urandom), $urandom, 3'd0);
      send_request(OP_PRESSED, PINS_W'($urandom), $urandom, 3'd6);
      send_request(OP_PRESSED, PINS_W'($urandom), $urandom, 3'd7);
      send_request(OP_SAMPLE, 7'h7F, 32'd130, 3'd2);
      send_request(OP_SAMPLE, 7'h7F, 32'd150, 3'd4);
      send_request(OP_RELEASED, PINS_W'($urandom), $urandom, 3'd3);
      send_request(OP_UNUSED, 7'h00, 32'hFFFF_FFFF, 3'd7);
      send_request(OP_SAMPLE, 7'h55, 32'hFFFF_FFF0, 3'd1);
      send_request(OP_SAMPLE, 7'h55, 32'h0000_0004, 3'd6);
      send_request(OP_PRESSED, PINS_W'($urandom), $urandom, 3'd1);
      send_request(OP_RELEASED, PINS_W'($urandom), $urandom, 3'd0);
      send_request(OP_SAMPLE, 7'h2A, 32'h0000_0000, 3'd3);
      pin_state = 7'h2A;
      time_ms   = 32'h0000_0000;

      // Zero window: a change is stable in the same sample
      drain_responses();
      write_debounce(16'd0);
      send_request(OP_SAMPLE, 7'h00, time_ms, 3'd0);
      send_request(OP_PRESSED, PINS_W'($urandom), $urandom, 3'd2);
      pin_state = 7'h00;
      run_phase(300);

      // Widest window, starting just before the time base wraps
      drain_responses();
      write_debounce(16'hFFFF);
      time_ms = 32'hFFFF_FFFF - $urandom_range(0, 200000);
      run_phase(300);

      drain_responses();
      write_debounce(16'd1);
      run_phase(250);

      // Long receiver stall while reads keep coming, so the input backs up
      drain_responses();
      write_debounce(DEB_W'($urandom_range(2, 200)));
      rsp_hold_cycles = 300;
      req_no_idle     = 1'b1;
      repeat (8) send_request(OP_PRESSED, PINS_W'($urandom), $urandom,
                              INDEX_W'($urandom_range(0, 7)));
      req_no_idle = 1'b0;
      run_phase(200);

      drain_responses();
      write_debounce(DEB_W'($urandom_range(0, 65535)));
      time_ms = $urandom;
      run_phase(300);

      drain_responses();
      write_debounce(DEBOUNCE_RESET);
      run_phase(300);

      drain_responses();
      write_debounce(DEB_W'($urandom_range(3, 50)));
      run_phase(280);

      // Wait for the last reads, then give the verdict
      drain_responses();
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### multi_button_debouncer_unit.f
hw/rtl/mbd_pkg.sv
hw/rtl/mbd_lane.sv
hw/rtl/mbd_merge.sv
hw/rtl/multi_button_debouncer_unit.sv
verif/mbd_checker.sv
verif/multi_button_debouncer_unit_test.sv
